// File: hw/rtl/rgb_to_hsv_converter_macros.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define R2H_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rgb2hsv: assertion failed");
// condition must never be seen outside reset
`define R2H_ASSERT_NEVER(name, cond, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rgb2hsv: forbidden condition seen");
`else
`define R2H_ASSERT(name, prop, clk, rst_n)
`define R2H_ASSERT_NEVER(name, cond, clk, rst_n)
`endif

`endif

// File: hw/rtl/rgb2hsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Widths, constants and the classified-pixel type shared by the converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

  // field widths
  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  // dividend width: 360 * 255 plus rounding offset stays below 2^17
  localparam int unsigned NumW  = 17;

  // arithmetic constants
  localparam int unsigned ChanMax    = 255;
  localparam int unsigned DegSector  = 60;
  localparam int unsigned DegGreen   = 120;
  localparam int unsigned DegBlue    = 240;
  localparam int unsigned DegFull    = 360;
  localparam int unsigned PctFull    = 100;

  // queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // hue sector, picked by the brightest channel
  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sec_e;

  // classified pixel handed from front to back
  typedef struct packed {
    sec_e             sec;   // sector
    logic             neg;   // difference of the other two is negative
    logic [ChanW-1:0] hi;    // brightest channel
    logic [ChanW-1:0] span;  // max - min
    logic [ChanW-1:0] diff;  // magnitude of the other two channels' difference
  } cls_t;

endpackage

// File: hw/rtl/rgb2hsv_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Accepts pixels, finds max/min and the hue sector, and queues the result.
// ----------------------------------------------------------------------------
module rgb2hsv_front import rgb2hsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output cls_t             q_data_o
);

  logic             vld_q, vld_d;
  cls_t             cls_q, cls_d;
  logic             accept;
  logic [ChanW-1:0] hi, lo, op_a, op_b;

  // handshake: slot frees when its item moves into the queue
  assign q_push_o = vld_q && !q_full_i;
  assign full_o   = vld_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_data_o = cls_q;

  // classification: ties go red, green, blue
  always_comb begin
    hi = (red_i > green_i) ? ((red_i > blue_i) ? red_i : blue_i)
                           : ((green_i > blue_i) ? green_i : blue_i);
    lo = (red_i < green_i) ? ((red_i < blue_i) ? red_i : blue_i)
                           : ((green_i < blue_i) ? green_i : blue_i);
    if (red_i == hi) begin
      cls_d.sec = SecRed;
      op_a      = green_i;
      op_b      = blue_i;
    end else if (green_i == hi) begin
      cls_d.sec = SecGreen;
      op_a      = blue_i;
      op_b      = red_i;
    end else begin
      cls_d.sec = SecBlue;
      op_a      = red_i;
      op_b      = green_i;
    end
    cls_d.neg  = op_a < op_b;
    cls_d.diff = cls_d.neg ? (op_b - op_a) : (op_a - op_b);
    cls_d.hi   = hi;
    cls_d.span = hi - lo;
  end

  // valid flag
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (q_push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

endmodule

// File: hw/rtl/rgb2hsv_fifo.sv
// ----------------------------------------------------------------------------
// RGB to HSV decoupling queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module rgb2hsv_fifo import rgb2hsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cls_t wdata_i,
  output logic full_o,
  input  logic rd_i,
  output cls_t rdata_o,
  output logic empty_o
);

  cls_t                entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign full_o  = cnt_q == FifoCntW'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/rgb2hsv_back.sv
// ----------------------------------------------------------------------------
// RGB to HSV back end
// Forms the rounded numerators and runs two pipelined restoring dividers
// (hue, saturation), three quotient bits per stage, into the result register.
// Value divides by the constant 255 with a reciprocal step in stage 1.
// ----------------------------------------------------------------------------
module rgb2hsv_back import rgb2hsv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  cls_t            q_data_i,
  output logic            q_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [HueW-1:0] hue_o,
  output logic [PctW-1:0] sat_o,
  output logic [PctW-1:0] val_o
);

  // partial division: running remainder and quotient bits so far
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [HueW-1:0] quo;
  } div_t;

  typedef struct packed {
    div_t             hue;
    div_t             sat;
    logic [PctW-1:0]  val;
    logic [ChanW-1:0] span;
    logic [ChanW-1:0] hi;
  } stg_t;

  // three restoring steps, quotient bit positions top down to top-2
  function automatic div_t div_step3(div_t acc, logic [ChanW-1:0] den, logic [3:0] top);
    div_t            res;
    logic [NumW-1:0] trial;
    logic [3:0]      shamt;
    res = acc;
    for (int unsigned k = 0; k < 3; k++) begin
      shamt = top - 4'(k);
      trial = NumW'(den) << shamt;
      if (res.rem >= trial) begin
        res.rem = res.rem - trial;
        res.quo = {res.quo[HueW-2:0], 1'b1};
      end else begin
        res.quo = {res.quo[HueW-2:0], 1'b0};
      end
    end
    return res;
  endfunction

  logic             adv;
  logic             v1_q, v2_q, v3_q, vo_q;
  stg_t             s1_q, s1_d, s2_q, s2_d, s3_q, s3_d;
  logic [HueW-1:0]  hue_q, hue_d;
  logic [PctW-1:0]  sat_q, sat_d, val_q, val_d;
  logic [NumW-1:0]  span_w, base, step;
  logic [NumW-1:0]  val_num, val_est;
  div_t             hue_f, sat_f;

  // whole pipeline moves when the result register is free or being taken
  assign adv     = !vo_q || pop_i;
  assign q_pop_o = adv && !q_empty_i;
  assign empty_o = !vo_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign val_o   = val_q;

  // stage 1: numerators, each with half the divisor added for rounding
  always_comb begin
    span_w = NumW'(q_data_i.span);
    step   = NumW'(q_data_i.diff) * NumW'(DegSector);
    unique case (q_data_i.sec)
      SecRed:   base = q_data_i.neg ? span_w * NumW'(DegFull) : '0;
      SecGreen: base = span_w * NumW'(DegGreen);
      SecBlue:  base = span_w * NumW'(DegBlue);
      default:  base = '0;
    endcase
    s1_d.hue.rem = (q_data_i.neg ? base - step : base + step) + NumW'(q_data_i.span >> 1);
    s1_d.hue.quo = '0;
    s1_d.sat.rem = span_w * NumW'(PctFull) + NumW'(q_data_i.hi >> 1);
    s1_d.sat.quo = '0;
    // value: x / 255 as (x + x/256 + 1) / 256, exact for x below 65535
    val_num      = NumW'(q_data_i.hi) * NumW'(PctFull) + NumW'(ChanMax >> 1);
    val_est      = val_num + (val_num >> 8) + NumW'(1);
    s1_d.val     = val_est[8 +: PctW];
    s1_d.span    = q_data_i.span;
    s1_d.hi      = q_data_i.hi;
  end

  // stage 2: quotient bits 8..6
  always_comb begin
    s2_d     = s1_q;
    s2_d.hue = div_step3(s1_q.hue, s1_q.span, 4'd8);
    s2_d.sat = div_step3(s1_q.sat, s1_q.hi, 4'd8);
  end

  // stage 3: quotient bits 5..3
  always_comb begin
    s3_d     = s2_q;
    s3_d.hue = div_step3(s2_q.hue, s2_q.span, 4'd5);
    s3_d.sat = div_step3(s2_q.sat, s2_q.hi, 4'd5);
  end

  // stage 4: quotient bits 2..0 and special cases (grey, black, 360 wrap)
  always_comb begin
    hue_f = div_step3(s3_q.hue, s3_q.span, 4'd2);
    sat_f = div_step3(s3_q.sat, s3_q.hi, 4'd2);
    hue_d = ((s3_q.span == '0) || (hue_f.quo >= HueW'(DegFull))) ? '0 : hue_f.quo;
    sat_d = (s3_q.hi == '0) ? '0 : sat_f.quo[PctW-1:0];
    val_d = s3_q.val;
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= !q_empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= val_d;
    end
  end

endmodule

// File: hw/rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts 8-bit RGB pixels to hue in degrees and saturation/value in percent.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a pixel (red_i, green_i, blue_i) is taken
// on a rising edge with push high and full low. Result side is a queue read
// port: while empty is low the oldest result sits on hue_o, saturation_o and
// brightness_o, and it is taken on a rising edge with pop high.
// From its transaction to its result showing, a pixel passes the front
// classification register, the four-entry queue, and the back-end stage 1,
// 2 and 3 registers and result register (three quotient bits per stage).
// Throughput is one pixel per clock; every stage is a single register step.
// When pop stays low the back end holds its pipeline, the queue absorbs up to
// four pixels, and full rises once the queue and front register are taken.
// Reset (rst_ni low, asynchronous) empties every stage and the queue; empty
// is high and full is low afterwards. All values are rounded to nearest with
// halves up; grey pixels give hue 0 and black pixels saturation 0.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter import rgb2hsv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic            empty,
  input  logic            pop,
  output logic [HueW-1:0] hue_o,
  output logic [PctW-1:0] saturation_o,
  output logic [PctW-1:0] brightness_o
);

  logic fifo_push, fifo_full, fifo_pop, fifo_empty;
  cls_t fifo_wdata, fifo_rdata;
  logic res_in_range;

  // front: accept and classify
  rgb2hsv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .q_full_i (fifo_full),
    .q_push_o (fifo_push),
    .q_data_o (fifo_wdata)
  );

  // queue between front and back
  rgb2hsv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fifo_push),
    .wdata_i (fifo_wdata),
    .full_o  (fifo_full),
    .rd_i    (fifo_pop),
    .rdata_o (fifo_rdata),
    .empty_o (fifo_empty)
  );

  // back: divide and deliver
  rgb2hsv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (fifo_empty),
    .q_data_i  (fifo_rdata),
    .q_pop_o   (fifo_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .hue_o     (hue_o),
    .sat_o     (saturation_o),
    .val_o     (brightness_o)
  );

  // shown result lies inside the field ranges
  assign res_in_range = (hue_o < HueW'(DegFull)) && (saturation_o <= PctW'(PctFull)) &&
                        (brightness_o <= PctW'(PctFull));

  // front never writes into a full queue
  `R2H_ASSERT_NEVER(a_no_push_full, fifo_push && fifo_full, clk_i, rst_ni)
  // back never reads an empty queue
  `R2H_ASSERT_NEVER(a_no_pop_empty, fifo_pop && fifo_empty, clk_i, rst_ni)
  // wrap and special-case logic keep every shown result in range
  `R2H_ASSERT(a_result_range, !empty |-> res_in_range, clk_i, rst_ni)
  // full only while the queue itself is full
  `R2H_ASSERT(a_full_backs_queue, full |-> fifo_full, clk_i, rst_ni)

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Feeds pixels through the push/full port and takes results from the
// empty/pop port, with random idle bursts on both sides. A directed table
// comes first, then about a thousand random pixels. Every result is compared
// field by field with the oldest entry of a queue that an in-bench predictor
// fills as each pixel transaction is accepted (typed rows supply their own).
// ----------------------------------------------------------------------------
module tb import rgb2hsv_pkg::*;;

  localparam int unsigned RandPixels = 1000;
  localparam int unsigned QuietLimit = 2000;

  // one conversion result
  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
  } hsv_t;

  // directed stimulus row; want is used only when typed is set
  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic             typed;
    hsv_t             want;
  } pixel_row_t;

  localparam int unsigned NumRows = 20;
  localparam pixel_row_t DirectedRows [NumRows] = '{
    '{  0,   0,   0, 1, '{  0,   0,   0}},  // black
    '{255, 255, 255, 1, '{  0,   0, 100}},  // white
    '{255,   0,   0, 1, '{  0, 100, 100}},  // pure red
    '{  0, 255,   0, 1, '{120, 100, 100}},  // pure green
    '{  0,   0, 255, 1, '{240, 100, 100}},  // pure blue
    '{255, 255,   0, 1, '{ 60, 100, 100}},  // red/green tie goes to red
    '{  0, 255, 255, 1, '{180, 100, 100}},  // green/blue tie goes to green
    '{255,   0, 255, 1, '{300, 100, 100}},  // red/blue tie, negative hue wraps
    '{128, 128, 128, 1, '{  0,   0,  50}},  // mid grey
    '{255,   0,   1, 1, '{  0, 100, 100}},  // hue rounds to 360, shown as 0
    '{  1,   0,   0, 0, '{  0,   0,   0}},
    '{200, 199, 199, 0, '{  0,   0,   0}},  // saturation on an exact half
    '{120,   1,   0, 0, '{  0,   0,   0}},  // hue on an exact half
    '{200, 255,   0, 0, '{  0,   0,   0}},  // green sector, red above blue
    '{  0, 100, 255, 0, '{  0,   0,   0}},  // blue sector, green above red
    '{100,   0, 255, 0, '{  0,   0,   0}},  // blue sector, red above green
    '{  1,   1,   1, 0, '{  0,   0,   0}},  // darkest grey
    '{170,  85,  51, 0, '{  0,   0,   0}},
    '{254,   1, 127, 0, '{  0,   0,   0}},
    '{ 85, 170, 254, 0, '{  0,   0,   0}}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic [ChanW-1:0] red_i;
  logic [ChanW-1:0] green_i;
  logic [ChanW-1:0] blue_i;
  logic             empty;
  logic             pop;
  logic [HueW-1:0]  hue_o;
  logic [PctW-1:0]  saturation_o;
  logic [PctW-1:0]  brightness_o;

  // typed expectation travels with the pixel and is sampled on acceptance
  logic             use_typed;
  hsv_t             typed_hsv;

  hsv_t             pending_hsv [$];
  int unsigned      mismatches;
  int unsigned      results_seen;
  int unsigned      quiet_cycles;
  bit               idle_on;

  rgb_to_hsv_converter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .empty        (empty),
    .pop          (pop),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // exact rational rounded to nearest, halves up
  function automatic int unsigned round_ratio(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // expected hue, saturation and value of one pixel
  function automatic hsv_t hsv_of(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                  logic [ChanW-1:0] b);
    int unsigned hi;
    int unsigned lo;
    int unsigned d;
    int unsigned num;
    int unsigned deg;
    hsv_t        res;
    hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    d  = hi - lo;
    res.sat = (hi == 0) ? '0 : PctW'(round_ratio(PctFull * d, hi));
    res.val = PctW'(round_ratio(PctFull * hi, ChanMax));
    if (d == 0) begin
      deg = 0;
    end else begin
      // sector by brightest channel, ties in red, green, blue order
      if (hi == r) begin
        num = (g >= b) ? DegSector * (g - b) : DegFull * d - DegSector * (b - g);
      end else if (hi == g) begin
        num = (b >= r) ? DegGreen * d + DegSector * (b - r)
                       : DegGreen * d - DegSector * (r - b);
      end else begin
        num = (r >= g) ? DegBlue * d + DegSector * (r - g)
                       : DegBlue * d - DegSector * (g - r);
      end
      deg = round_ratio(num, d);
      if (deg >= DegFull) deg = 0;
    end
    res.hue = HueW'(deg);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // transaction monitor: predict on push, check on pop
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni) begin
      if (push && !full) begin
        pending_hsv.push_back(use_typed ? typed_hsv : hsv_of(red_i, green_i, blue_i));
      end
      if (pop && !empty) begin
        results_seen++;
        if (pending_hsv.size() == 0) begin
          report_mismatch("unexpected result, hue", hue_o, 0);
        end else begin
          want = pending_hsv.pop_front();
          if (hue_o !== want.hue) report_mismatch("hue", hue_o, want.hue);
          if (saturation_o !== want.sat) report_mismatch("saturation", saturation_o, want.sat);
          if (brightness_o !== want.val) report_mismatch("brightness", brightness_o, want.val);
        end
      end
      quiet_cycles <= ((push && !full) || (pop && !empty)) ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  // result side: pop with random stall bursts
  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // offer one pixel and hold it until the transaction completes
  task automatic send_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                            logic [ChanW-1:0] b, logic typed, hsv_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push      <= 1'b1;
    red_i     <= r;
    green_i   <= g;
    blue_i    <= b;
    use_typed <= typed;
    typed_hsv <= want;
    do @(posedge clk_i); while (full);
  endtask

  // hold off input until every outstanding result has been taken;
  // the wait for the falling edge lets the monitor record the last accepted pixel
  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending_hsv.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ChanW-1:0] pick_edge();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(0, ChanMax));
    endcase
  endfunction

  // stimulus
  initial begin
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    rst_ni       = 1'b0;
    push         = 1'b0;
    red_i        = '0;
    green_i      = '0;
    blue_i       = '0;
    use_typed    = 1'b0;
    typed_hsv    = '0;
    idle_on      = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (DirectedRows[i]) begin
      send_pixel(DirectedRows[i].r, DirectedRows[i].g, DirectedRows[i].b,
                 DirectedRows[i].typed, DirectedRows[i].want);
    end
    drain_results();

    // random pixels; the tail runs with no idling on either side
    for (int i = 0; i < RandPixels; i++) begin
      if (i == RandPixels / 2) drain_results();
      if (i == RandPixels - 150) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          r = ChanW'($urandom_range(0, ChanMax));
          g = r;
          b = r;
        end
        1: begin
          // red brightest, blue just above green: hue near the wrap
          r = ChanW'($urandom_range(122, ChanMax));
          g = ChanW'($urandom_range(0, r - 122));
          b = g + 1'b1;
        end
        2: begin
          r = pick_edge();
          g = pick_edge();
          b = pick_edge();
        end
        default: begin
          r = ChanW'($urandom_range(0, ChanMax));
          g = ChanW'($urandom_range(0, ChanMax));
          b = ChanW'($urandom_range(0, ChanMax));
        end
      endcase
      send_pixel(r, g, b, 1'b0, '0);
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: rgb_to_hsv_converter.f
+incdir+hw/rtl
hw/rtl/rgb2hsv_pkg.sv
hw/rtl/rgb2hsv_front.sv
hw/rtl/rgb2hsv_fifo.sv
hw/rtl/rgb2hsv_back.sv
hw/rtl/rgb_to_hsv_converter.sv
test/tb.sv
